// ----- sv/cab_pkg.sv -----
// ----------------------------------------------------------------------------
// cab_pkg: shared definitions of the cyclic asynchronous buffer manager
// Request kinds, status codes, field widths and the controller command word.
// ----------------------------------------------------------------------------
package cab_pkg;

	localparam int NUM_BUFFERS_DEF = 8;
	localparam int USE_WIDTH_DEF   = 8;

	localparam int KIND_W = 2;
	localparam int IDX_W  = 3;
	localparam int STAT_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_RESERVE = 2'd0,
		KIND_PUT     = 2'd1,
		KIND_GET     = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NO_MSG    = 2'd2,
		STAT_UNDERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cab_cmd_t;

endpackage

// ----- sv/cab_ram.sv -----
// ----------------------------------------------------------------------------
// cab_ram: generic single write port, single read port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/cab_ctrl.sv -----
// ----------------------------------------------------------------------------
// cab_ctrl: request sequencer
// Takes a word in the idle state and runs its write-back in the next cycle.
// ----------------------------------------------------------------------------
module cab_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output cab_pkg::cab_cmd_t cmd
);

	import cab_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign cmd.load = start && (state_q == ST_IDLE);
	assign cmd.exec = (state_q == ST_EXEC);

endmodule

// ----- sv/cab_datapath.sv -----
// ----------------------------------------------------------------------------
// cab_datapath: free list, use counts and latest message buffer
// Reads the link and count memories on load, writes them back on exec.
// ----------------------------------------------------------------------------
module cab_datapath #(
	parameter int NUM_BUFFERS = cab_pkg::NUM_BUFFERS_DEF,
	parameter int USE_WIDTH   = cab_pkg::USE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cab_pkg::cab_cmd_t          cmd,
	input  logic [cab_pkg::KIND_W-1:0] kind,
	input  logic [cab_pkg::IDX_W-1:0]  buffer_index,
	output logic                       done,
	output logic [cab_pkg::IDX_W-1:0]  result_index,
	output logic [cab_pkg::STAT_W-1:0] status
);

	import cab_pkg::*;

	localparam int IW = $clog2(NUM_BUFFERS);
	localparam int LW = $clog2(NUM_BUFFERS + 1);
	localparam logic [USE_WIDTH-1:0] USE_MAX  = '1;
	localparam logic [LW-1:0]        LINK_END = LW'(NUM_BUFFERS);

	// Architectural state
	logic [IW-1:0]          free_head_q, free_head_d;
	logic                   free_valid_q, free_valid_d;
	logic [IW-1:0]          latest_q, latest_d;
	logic                   latest_valid_q, latest_valid_d;
	logic [NUM_BUFFERS-1:0] uc_vld_q;
	logic [NUM_BUFFERS-1:0] nf_vld_q;

	// Request held over the execute cycle
	kind_t                  kind_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IW-1:0]          uc_addr_q;
	logic                   ucv_q;
	logic                   nfv_q;

	logic                   done_q;
	logic [IDX_W-1:0]       res_q;
	status_t                st_q;

	// Memory ports
	logic [IW-1:0]          uc_raddr;
	logic [USE_WIDTH-1:0]   uc_rdata, uc_wdata;
	logic                   uc_we;
	logic [LW-1:0]          nf_rdata, nf_wdata;
	logic [IW-1:0]          nf_waddr;
	logic                   nf_we;

	// Execute logic
	logic                   b_ok;
	logic [IW-1:0]          b_ix;
	logic                   is_latest;
	logic [USE_WIDTH-1:0]   uc;
	logic [LW-1:0]          nx;
	logic                   push;
	logic [IW-1:0]          push_ix;
	logic [IDX_W-1:0]       res_d;
	status_t                st_d;

	assign uc_raddr = (kind_t'(kind) == KIND_RELEASE) ? IW'(buffer_index) : latest_q;

	cab_ram #(
		.WIDTH(USE_WIDTH),
		.DEPTH(NUM_BUFFERS)
	) u_use_ram (
		.clk  (clk),
		.we   (uc_we),
		.waddr(uc_addr_q),
		.wdata(uc_wdata),
		.re   (cmd.load),
		.raddr(uc_raddr),
		.rdata(uc_rdata)
	);

	cab_ram #(
		.WIDTH(LW),
		.DEPTH(NUM_BUFFERS)
	) u_link_ram (
		.clk  (clk),
		.we   (nf_we),
		.waddr(nf_waddr),
		.wdata(nf_wdata),
		.re   (cmd.load),
		.raddr(free_head_q),
		.rdata(nf_rdata)
	);

	// An entry never written holds its reset value: a zero count, or a link
	// to the following buffer.
	assign uc = ucv_q ? uc_rdata : '0;
	assign nx = nfv_q ? nf_rdata : (LW'(free_head_q) + LW'(1));

	assign b_ok      = (32'(idx_q) < NUM_BUFFERS);
	assign b_ix      = IW'(idx_q);
	assign is_latest = latest_valid_q && b_ok && (b_ix == latest_q);

	always_comb begin
		free_head_d    = free_head_q;
		free_valid_d   = free_valid_q;
		latest_d       = latest_q;
		latest_valid_d = latest_valid_q;
		uc_we          = 1'b0;
		uc_wdata       = uc;
		push           = 1'b0;
		push_ix        = b_ix;
		res_d          = '0;
		st_d           = STAT_OK;
		unique case (kind_q)
			KIND_RESERVE: begin
				if (!free_valid_q) begin
					st_d = STAT_EMPTY;
				end else begin
					res_d = IDX_W'(free_head_q);
					if (32'(nx) < NUM_BUFFERS) begin
						free_head_d = IW'(nx);
					end else begin
						free_head_d  = '0;
						free_valid_d = 1'b0;
					end
				end
			end
			KIND_PUT: begin
				if (b_ok && !is_latest) begin
					if (latest_valid_q && (uc == '0)) begin
						push    = 1'b1;
						push_ix = latest_q;
					end
					latest_d       = b_ix;
					latest_valid_d = 1'b1;
				end
			end
			KIND_GET: begin
				if (!latest_valid_q) begin
					st_d = STAT_NO_MSG;
				end else begin
					uc_we    = 1'b1;
					uc_wdata = (uc != USE_MAX) ? uc + USE_WIDTH'(1) : uc;
					res_d    = IDX_W'(latest_q);
				end
			end
			KIND_RELEASE: begin
				if (b_ok) begin
					if (uc == '0) begin
						st_d = STAT_UNDERFLOW;
					end else begin
						uc_we    = 1'b1;
						uc_wdata = uc - USE_WIDTH'(1);
						if ((uc == USE_WIDTH'(1)) && !is_latest) begin
							push    = 1'b1;
							push_ix = b_ix;
						end
					end
				end
			end
			default: ;
		endcase
		// Pushing links the buffer in front of the current head.
		if (push) begin
			free_head_d  = push_ix;
			free_valid_d = 1'b1;
		end
		uc_we = uc_we && cmd.exec;
	end

	assign nf_we    = push && cmd.exec;
	assign nf_waddr = push_ix;
	assign nf_wdata = free_valid_q ? LW'(free_head_q) : LINK_END;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q    <= '0;
			free_valid_q   <= 1'b1;
			latest_q       <= '0;
			latest_valid_q <= 1'b0;
			uc_vld_q       <= '0;
			nf_vld_q       <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				free_head_q    <= free_head_d;
				free_valid_q   <= free_valid_d;
				latest_q       <= latest_d;
				latest_valid_q <= latest_valid_d;
			end
			if (uc_we) uc_vld_q[uc_addr_q] <= 1'b1;
			if (nf_we) nf_vld_q[nf_waddr]  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind_t'(kind);
			idx_q     <= buffer_index;
			uc_addr_q <= uc_raddr;
			ucv_q     <= uc_vld_q[uc_raddr];
			nfv_q     <= nf_vld_q[free_head_q];
		end
		if (cmd.exec) begin
			res_q <= res_d;
			st_q  <= st_d;
		end
	end

	assign done         = done_q;
	assign result_index = res_q;
	assign status       = st_q;

endmodule

// ----- sv/cyclic_async_buffer_manager.sv -----
// ----------------------------------------------------------------------------
// cyclic_async_buffer_manager: cyclic asynchronous buffer pool manager
// Free list, per-buffer use counts and latest message for one writer and
// many readers.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. The block then
// spends one cycle busy: the accepting edge reads the link and use-count
// memories, and the following edge writes them back and registers the
// result. The result appears with done for exactly one cycle, starting at the
// first edge after acceptance, and cannot be held off; a new request may be
// taken at the edge that ends that cycle, so the block sustains one request
// every two cycles, set by the registered read of the two memories. No
// clearing pass is needed after reset: per-entry valid bits supply the reset
// contents.
module cyclic_async_buffer_manager #(
	parameter int NUM_BUFFERS = cab_pkg::NUM_BUFFERS_DEF,
	parameter int USE_WIDTH   = cab_pkg::USE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [cab_pkg::KIND_W-1:0] kind,
	input  logic [cab_pkg::IDX_W-1:0]  buffer_index,
	output logic                       done,
	output logic [cab_pkg::IDX_W-1:0]  result_index,
	output logic [cab_pkg::STAT_W-1:0] status
);

	import cab_pkg::*;

	cab_cmd_t cmd;

	cab_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd)
	);

	cab_datapath #(
		.NUM_BUFFERS(NUM_BUFFERS),
		.USE_WIDTH  (USE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.buffer_index(buffer_index),
		.done        (done),
		.result_index(result_index),
		.status      (status)
	);

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the cyclic asynchronous buffer manager
// A short table of directed request words, then a long run of random writer
// and reader sequences with noise. Each result word is compared with a local
// model of the free list, use counts and latest message, or for typed rows with the table.
// ----------------------------------------------------------------------------
module tb_top;
	import cab_pkg::*;

	localparam int NB           = NUM_BUFFERS_DEF;
	localparam int UW           = USE_WIDTH_DEF;
	localparam int RANDOM_ITEMS = 450;
	localparam int SAT_RUN      = 260;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int N_DIRECTED   = 25;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		status_t          st;
	} outcome_t;

	typedef struct packed {
		kind_t            k;
		logic [IDX_W-1:0] idx;
		logic             typed;
		logic [IDX_W-1:0] er;
		status_t          es;
	} stim_row_t;

	// Rows marked typed carry a result that is obvious from the state at that
	// point; the rest are checked against the model.
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{KIND_GET,     3'd5, 1'b1, 3'd0, STAT_NO_MSG},
		'{KIND_RELEASE, 3'd0, 1'b1, 3'd0, STAT_UNDERFLOW},
		'{KIND_RELEASE, 3'd7, 1'b1, 3'd0, STAT_UNDERFLOW},
		'{KIND_RESERVE, 3'd7, 1'b1, 3'd0, STAT_OK},
		'{KIND_RESERVE, 3'd0, 1'b1, 3'd1, STAT_OK},
		'{KIND_PUT,     3'd1, 1'b1, 3'd0, STAT_OK},
		'{KIND_PUT,     3'd1, 1'b0, 3'd0, STAT_OK},
		'{KIND_GET,     3'd0, 1'b1, 3'd1, STAT_OK},
		'{KIND_GET,     3'd3, 1'b0, 3'd0, STAT_OK},
		'{KIND_PUT,     3'd0, 1'b0, 3'd0, STAT_OK},
		'{KIND_RELEASE, 3'd1, 1'b0, 3'd0, STAT_OK},
		'{KIND_RELEASE, 3'd1, 1'b0, 3'd0, STAT_OK},
		'{KIND_GET,     3'd2, 1'b0, 3'd0, STAT_OK},
		'{KIND_PUT,     3'd7, 1'b0, 3'd0, STAT_OK},
		'{KIND_RELEASE, 3'd0, 1'b0, 3'd0, STAT_OK},
		'{KIND_RESERVE, 3'd0, 1'b0, 3'd0, STAT_OK},
		'{KIND_RESERVE, 3'd1, 1'b0, 3'd0, STAT_OK},
		'{KIND_RESERVE, 3'd2, 1'b0, 3'd0, STAT_OK},
		'{KIND_RESERVE, 3'd3, 1'b0, 3'd0, STAT_OK},
		'{KIND_RESERVE, 3'd4, 1'b0, 3'd0, STAT_OK},
		'{KIND_RESERVE, 3'd5, 1'b0, 3'd0, STAT_OK},
		'{KIND_RESERVE, 3'd6, 1'b0, 3'd0, STAT_OK},
		'{KIND_RESERVE, 3'd7, 1'b0, 3'd0, STAT_OK},
		'{KIND_RESERVE, 3'd4, 1'b1, 3'd0, STAT_EMPTY},
		'{KIND_PUT,     3'd3, 1'b0, 3'd0, STAT_OK}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [KIND_W-1:0] kind = KIND_RESERVE;
	logic [IDX_W-1:0] buffer_index = '0;
	logic             busy;
	logic             done;
	logic [IDX_W-1:0] result_index;
	logic [STAT_W-1:0] status;

	// Local copy of the pool state.
	int               pool_head;
	bit               pool_nonempty;
	int               pool_link [NB];
	logic [UW-1:0]    readers [NB];
	logic [IDX_W-1:0] latest_buf;
	bit               latest_ok;

	outcome_t         pending_results [$];
	logic [IDX_W-1:0] reserved_bufs [$];
	logic [IDX_W-1:0] held_bufs [$];

	int errors = 0;
	int n_checked = 0;
	int n_sent = 0;
	int cycles = 0;
	int calm_left = 0;
	int status_seen [4] = '{0, 0, 0, 0};

	cyclic_async_buffer_manager u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.buffer_index (buffer_index),
		.done         (done),
		.result_index (result_index),
		.status       (status)
	);

	always #5 clk = ~clk;

	function automatic void pool_clear();
		for (int i = 0; i < NB; i++) begin
			pool_link[i] = i + 1;
			readers[i] = '0;
		end
		pool_head = 0;
		pool_nonempty = 1'b1;
		latest_buf = '0;
		latest_ok = 1'b0;
	endfunction

	function automatic void pool_push(input logic [IDX_W-1:0] b);
		pool_link[b] = pool_nonempty ? pool_head : NB;
		pool_head = int'(b);
		pool_nonempty = 1'b1;
	endfunction

	// Applies one request word to the local pool and gives back its result.
	task automatic pool_apply(input kind_t k, input logic [IDX_W-1:0] b,
			output logic [IDX_W-1:0] r, output status_t s);
		int nx;
		r = '0;
		s = STAT_OK;
		case (k)
			KIND_RESERVE: begin
				if (!pool_nonempty || pool_head >= NB) begin
					s = STAT_EMPTY;
				end else begin
					nx = pool_link[pool_head];
					r = pool_head[IDX_W-1:0];
					if (nx < NB) begin
						pool_head = nx;
					end else begin
						pool_head = 0;
						pool_nonempty = 1'b0;
					end
				end
			end
			KIND_PUT: begin
				if (int'(b) < NB && !(latest_ok && b == latest_buf)) begin
					if (latest_ok && readers[latest_buf] == '0)
						pool_push(latest_buf);
					latest_buf = b;
					latest_ok = 1'b1;
				end
			end
			KIND_GET: begin
				if (!latest_ok) begin
					s = STAT_NO_MSG;
				end else begin
					if (readers[latest_buf] != '1)
						readers[latest_buf] = readers[latest_buf] + UW'(1);
					r = latest_buf;
				end
			end
			default: begin
				if (int'(b) < NB) begin
					if (readers[b] == '0) begin
						s = STAT_UNDERFLOW;
					end else begin
						readers[b] = readers[b] - UW'(1);
						if (readers[b] == '0 && !(latest_ok && b == latest_buf))
							pool_push(b);
					end
				end
			end
		endcase
	endtask

	function automatic int pick_gap();
		int p;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 3) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// Presents one word, waits until it is taken and updates the local pool.
	// Start is only lowered when a gap follows, so back-to-back words keep it
	// high without a second assignment in the same step.
	task automatic issue(input kind_t k, input logic [IDX_W-1:0] b,
			output logic [IDX_W-1:0] r, output status_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			kind <= KIND_W'($urandom_range(0, 3));
			buffer_index <= IDX_W'($urandom_range(0, 7));
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		buffer_index <= b;
		do @(posedge clk); while (busy);
		pool_apply(k, b, r, s);
		n_sent++;
	endtask

	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word: result_index %0d status %0d",
					$time, result_index, status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				status_seen[status]++;
				if (result_index !== want.idx) begin
					$display("%0t: result_index expected %0d actual %0d",
						$time, want.idx, result_index);
					errors++;
				end
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.st, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run stopped at the cycle limit", $time);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		kind_t            k;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] r;
		status_t          s;
		logic [IDX_W-1:0] sat_buf;
		int               sel;
		int               pos;

		pool_clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			issue(DIRECTED[i].k, DIRECTED[i].idx, r, s);
			if (DIRECTED[i].typed)
				pending_results.push_back(outcome_t'{idx: DIRECTED[i].er, st: DIRECTED[i].es});
			else
				pending_results.push_back(outcome_t'{idx: r, st: s});
		end

		// Mostly writer and reader sequences: reserve then put the reserved
		// buffer, get then release a held buffer. The rest is noise.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sel = $urandom_range(0, 99);
			b = IDX_W'($urandom_range(0, 7));
			k = KIND_RESERVE;
			if (sel < 20) begin
				k = KIND_RESERVE;
			end else if (sel < 40) begin
				k = KIND_PUT;
				if (reserved_bufs.size() > 0) begin
					pos = $urandom_range(0, reserved_bufs.size() - 1);
					b = reserved_bufs[pos];
					reserved_bufs.delete(pos);
				end
			end else if (sel < 65) begin
				k = KIND_GET;
			end else if (sel < 90) begin
				k = KIND_RELEASE;
				if (held_bufs.size() > 0) begin
					pos = $urandom_range(0, held_bufs.size() - 1);
					b = held_bufs[pos];
					held_bufs.delete(pos);
				end
			end else begin
				k = kind_t'($urandom_range(0, 3));
			end
			issue(k, b, r, s);
			pending_results.push_back(outcome_t'{idx: r, st: s});
			if (s == STAT_OK && k == KIND_RESERVE)
				reserved_bufs.push_back(r);
			if (s == STAT_OK && k == KIND_GET)
				held_bufs.push_back(r);

			// Halfway through, drive one buffer's use count into saturation
			// and then back down past zero.
			if (i == RANDOM_ITEMS / 2) begin
				issue(KIND_PUT, IDX_W'($urandom_range(0, 7)), r, s);
				pending_results.push_back(outcome_t'{idx: r, st: s});
				sat_buf = '0;
				for (int j = 0; j < SAT_RUN; j++) begin
					issue(KIND_GET, IDX_W'($urandom_range(0, 7)), r, s);
					pending_results.push_back(outcome_t'{idx: r, st: s});
					sat_buf = r;
				end
				for (int j = 0; j < SAT_RUN; j++) begin
					issue(KIND_RELEASE, sat_buf, r, s);
					pending_results.push_back(outcome_t'{idx: r, st: s});
				end
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d request words and checked %0d result words.", n_sent, n_checked);
		$display("Statuses seen: ok %0d, pool empty %0d, no message %0d, underflow %0d.",
			status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_NO_MSG],
			status_seen[STAT_UNDERFLOW]);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- cyclic_async_buffer_manager.f -----
sv/cab_pkg.sv
sv/cab_ram.sv
sv/cab_ctrl.sv
sv/cab_datapath.sv
sv/cyclic_async_buffer_manager.sv
tb/tb_top.sv
